>>> rtl/core/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SRTH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("srth assertion failed");
`define SRTH_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("srth forbidden condition seen");
`else
`define SRTH_ASSERT(lbl, clk, rst_n, prop)
`define SRTH_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/srth_pkg.sv
package srth_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 64;
	localparam int unsigned STREAM_SLOTS_DEF  = 4;
	localparam int unsigned SLOT_FIELD_W      = 2;
	localparam int unsigned REPORT_W          = 32;
	localparam int unsigned MS_W              = 42;
	localparam int unsigned COMPACT_SHIFT     = 16;
	localparam int unsigned MS_PER_SEC        = 1000;
	localparam int unsigned FRAC_MS_W         = 10;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic                    op;
		logic [SLOT_FIELD_W-1:0] stream_slot;
		logic [31:0]             ntp_seconds;
		logic [31:0]             ntp_fraction;
		logic [31:0]             query_report;
	} req_t;

	typedef struct packed {
		logic            found;
		logic [MS_W-1:0] send_time_ms;
	} rsp_t;

	typedef struct packed {
		logic [REPORT_W-1:0] report;
		logic [MS_W-1:0]     ms;
	} entry_t;

	// lookup request traveling down the chain
	typedef struct packed {
		logic                    valid;
		logic                    done;
		logic                    found;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [REPORT_W-1:0]     query;
		logic [MS_W-1:0]         ms;
	} token_t;

	function automatic logic [REPORT_W-1:0] compact_ntp(input logic [31:0] sec,
		input logic [31:0] frac);
		logic [REPORT_W-1:0] hi;
		logic [REPORT_W-1:0] lo;
		hi = sec << COMPACT_SHIFT;
		lo = frac >> COMPACT_SHIFT;
		return hi + lo;
	endfunction

	// seconds * 1000 plus fraction in ms, rounded half up
	function automatic logic [MS_W-1:0] ntp_to_ms(input logic [31:0] sec,
		input logic [31:0] frac);
		logic [MS_W-1:0]      sec_ms;
		logic [MS_W-1:0]      frac_scaled;
		logic [FRAC_MS_W-1:0] frac_ms;
		sec_ms      = MS_W'(sec) * MS_W'(MS_PER_SEC);
		frac_scaled = MS_W'(frac) * MS_W'(MS_PER_SEC) + (MS_W'(1) << 31);
		frac_ms     = frac_scaled[32 +: FRAC_MS_W];
		return sec_ms + MS_W'(frac_ms);
	endfunction

endpackage

>>> rtl/core/srth_cell.sv
module srth_cell #(
	parameter int unsigned STREAM_SLOTS = srth_pkg::STREAM_SLOTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  is_head,
	input  logic                                  shift_en,
	input  logic [srth_pkg::SLOT_FIELD_W-1:0]     shift_slot,
	input  srth_pkg::entry_t                      shift_in,
	output srth_pkg::entry_t                      shift_out,
	input  srth_pkg::token_t                      tok_in,
	output srth_pkg::token_t                      tok_out
);

	localparam int unsigned SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

	srth_pkg::entry_t entries_q [STREAM_SLOTS];
	srth_pkg::token_t tok_q;
	srth_pkg::token_t tok_nxt;
	srth_pkg::entry_t rd_entry;
	logic [SLOT_W-1:0] wr_idx;
	logic [SLOT_W-1:0] rd_idx;

	assign wr_idx    = SLOT_W'(shift_slot);
	assign rd_idx    = tok_in.valid ? SLOT_W'(tok_in.slot) : wr_idx;
	assign rd_entry  = entries_q[rd_idx];
	assign shift_out = rd_entry;
	assign tok_out   = tok_q;

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && !tok_in.done) begin
			// newest entry zero means nothing was sent on this slot or the newest record had a zero compact value
			if (is_head && (rd_entry.report == '0)) begin
				tok_nxt.done = 1'b1;
			end else if (rd_entry.report == tok_in.query) begin
				tok_nxt.done  = 1'b1;
				tok_nxt.found = 1'b1;
				tok_nxt.ms    = rd_entry.ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			for (int i = 0; i < int'(STREAM_SLOTS); i++) begin
				entries_q[i] <= '0;
			end
		end else begin
			tok_q <= tok_nxt;
			if (shift_en) begin
				entries_q[wr_idx] <= shift_in;
			end
		end
	end

endmodule

>>> rtl/core/sender_report_time_history.sv
// Sender report time history.
// One request channel (start/busy, request) and one result channel (strobe, result).
// A request is taken at a clock edge where start is high and busy is low.
// Record requests (op = 0) shift the slot's history in every cell at once and
// store the compact NTP value and the millisecond send time as the newest entry;
// they produce no result and leave busy low.
// Lookup requests (op = 1) enter the first cell and move one cell per clock down
// the chain of HISTORY_DEPTH cells, each comparing its own entry for the slot.
// The result is on the result port for exactly one cycle, marked by strobe,
// and comes from the token register of the last cell; busy is high from the
// edge that takes a lookup through its strobe cycle, so no new request is taken
// while a lookup is in the chain.
// The chain length sets the lookup latency and the lookup rate.
// The receiver cannot stall: a result is gone after its strobe cycle.
// Reset clears every history entry and any lookup in flight; the block takes
// requests in the first cycle after reset is released.
`include "assert_macros.svh"

module sender_report_time_history #(
	parameter int unsigned HISTORY_DEPTH = srth_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned STREAM_SLOTS  = srth_pkg::STREAM_SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  srth_pkg::req_t  request,
	output logic            strobe,
	output srth_pkg::rsp_t  result
);

	srth_pkg::entry_t shift_chain [HISTORY_DEPTH+1];
	srth_pkg::token_t tok_chain   [HISTORY_DEPTH+1];
	logic [HISTORY_DEPTH-1:0] tok_valid;
	srth_pkg::token_t tok_head;
	logic take;
	logic slot_ok;
	logic shift_en;
	logic busy_q;

	assign take     = start && !busy_q;
	assign slot_ok  = 32'(request.stream_slot) < 32'(STREAM_SLOTS);
	assign shift_en = take && (request.op == srth_pkg::OP_RECORD) && slot_ok;

	assign shift_chain[0].report = srth_pkg::compact_ntp(request.ntp_seconds,
		request.ntp_fraction);
	assign shift_chain[0].ms     = srth_pkg::ntp_to_ms(request.ntp_seconds,
		request.ntp_fraction);

	always_comb begin
		tok_head       = '0;
		tok_head.valid = take && (request.op == srth_pkg::OP_LOOKUP);
		tok_head.slot  = request.stream_slot;
		tok_head.query = request.query_report;
		tok_head.done  = !slot_ok || (request.query_report == '0);
	end
	assign tok_chain[0] = tok_head;

	for (genvar k = 0; k < int'(HISTORY_DEPTH); k++) begin : g_cell
		srth_cell #(
			.STREAM_SLOTS(STREAM_SLOTS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.is_head   ((k == 0) ? 1'b1 : 1'b0),
			.shift_en  (shift_en),
			.shift_slot(request.stream_slot),
			.shift_in  (shift_chain[k]),
			.shift_out (shift_chain[k+1]),
			.tok_in    (tok_chain[k]),
			.tok_out   (tok_chain[k+1])
		);
		assign tok_valid[k] = tok_chain[k+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (tok_chain[HISTORY_DEPTH].valid) begin
			busy_q <= 1'b0;
		end else if (tok_head.valid) begin
			busy_q <= 1'b1;
		end
	end

	assign busy                = busy_q;
	assign strobe              = tok_chain[HISTORY_DEPTH].valid;
	assign result.found        = tok_chain[HISTORY_DEPTH].found;
	assign result.send_time_ms = tok_chain[HISTORY_DEPTH].ms;

	`SRTH_ASSERT(a_strobe_while_busy, clk, arst_n, strobe |-> busy)
	`SRTH_ASSERT(a_lookup_sets_busy, clk, arst_n, tok_head.valid |=> busy)
	`SRTH_ASSERT(a_strobe_frees, clk, arst_n, strobe |=> !busy)
	`SRTH_ASSERT(a_one_lookup_in_flight, clk, arst_n, $onehot0(tok_valid))
	`SRTH_NEVER(a_miss_is_zero, clk, arst_n,
		strobe && !result.found && (result.send_time_ms != '0))

endmodule

>>> dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = srth_pkg::HISTORY_DEPTH_DEF;
	localparam int SLOTS       = srth_pkg::STREAM_SLOTS_DEF;
	localparam int N_RANDOM    = 1500;
	localparam int LOG_KEEP    = DEPTH + 16;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 2 * DEPTH + 20;
	localparam int N_DIRECTED  = 21;

	typedef struct packed {
		srth_pkg::req_t req;
		logic           fixed;
		srth_pkg::rsp_t rsp;
	} dir_row_t;

	logic           clk     = 1'b0;
	logic           arst_n  = 1'b0;
	logic           start   = 1'b0;
	srth_pkg::req_t request = '0;
	logic           busy;
	logic           strobe;
	srth_pkg::rsp_t result;

	sender_report_time_history u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.strobe  (strobe),
		.result  (result)
	);

	always #1 clk = ~clk;

	logic [srth_pkg::REPORT_W-1:0] hist_report [SLOTS][DEPTH];
	logic [srth_pkg::MS_W-1:0]     hist_ms     [SLOTS][DEPTH];
	logic [srth_pkg::REPORT_W-1:0] sent_log    [SLOTS][$];
	srth_pkg::rsp_t                pending_rsp [$];
	int                            errors      = 0;
	int                            idle_cycles = 0;
	dir_row_t                      dir_tab [N_DIRECTED];

	function automatic logic [srth_pkg::REPORT_W-1:0] compact_of(input logic [31:0] sec,
		input logic [31:0] frac);
		logic [31:0] hi;
		logic [31:0] lo;
		hi = sec << 16;
		lo = frac >> 16;
		return hi + lo;
	endfunction

	function automatic logic [srth_pkg::MS_W-1:0] ms_of(input logic [31:0] sec,
		input logic [31:0] frac);
		logic [63:0] frac_scaled;
		logic [63:0] total;
		frac_scaled = 64'(frac) * 64'd1000 + 64'h8000_0000;
		total       = 64'(sec) * 64'd1000 + (frac_scaled >> 32);
		return total[srth_pkg::MS_W-1:0];
	endfunction

	function automatic srth_pkg::rsp_t lookup_time(input int unsigned slot,
		input logic [31:0] query);
		srth_pkg::rsp_t r;
		r = '0;
		if (query != 0 && hist_report[slot][0] != 0) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!r.found && hist_report[slot][i] == query) begin
					r.found        = 1'b1;
					r.send_time_ms = hist_ms[slot][i];
				end
			end
		end
		return r;
	endfunction

	function automatic void record_report(input int unsigned slot, input logic [31:0] sec,
		input logic [31:0] frac);
		for (int i = DEPTH - 1; i > 0; i--) begin
			hist_report[slot][i] = hist_report[slot][i-1];
			hist_ms[slot][i]     = hist_ms[slot][i-1];
		end
		hist_report[slot][0] = compact_of(sec, frac);
		hist_ms[slot][0]     = ms_of(sec, frac);
		sent_log[slot].push_back(hist_report[slot][0]);
		if (sent_log[slot].size() > LOG_KEEP)
			void'(sent_log[slot].pop_front());
	endfunction

	// called at a rising edge; returns at the edge that takes the request
	task automatic send_req(input srth_pkg::req_t r, input int gap, input logic fixed,
		input srth_pkg::rsp_t fixed_rsp);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(negedge clk); while (busy);
		if (r.op == srth_pkg::OP_RECORD)
			record_report(32'(r.stream_slot), r.ntp_seconds, r.ntp_fraction);
		else if (fixed)
			pending_rsp.push_back(fixed_rsp);
		else
			pending_rsp.push_back(lookup_time(32'(r.stream_slot), r.query_report));
		@(posedge clk);
	endtask

	always @(negedge clk) begin : result_check
		srth_pkg::rsp_t exp_rsp;
		if (arst_n) begin
			if (strobe) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected result found=%0b send_time_ms=%0d",
						$time, result.found, result.send_time_ms);
					errors++;
				end else begin
					exp_rsp = pending_rsp.pop_front();
					if (result.found !== exp_rsp.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, exp_rsp.found, result.found);
						errors++;
					end
					if (result.send_time_ms !== exp_rsp.send_time_ms) begin
						$display("%0t: send_time_ms expected %0d actual %0d",
							$time, exp_rsp.send_time_ms, result.send_time_ms);
						errors++;
					end
				end
			end
			if (strobe || (start && !busy)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		srth_pkg::req_t r;
		int             gap;
		int             pick;
		int unsigned    slot;
		logic [31:0]    c;
		logic           no_gaps;

		for (int s = 0; s < SLOTS; s++) begin
			for (int i = 0; i < DEPTH; i++) begin
				hist_report[s][i] = '0;
				hist_ms[s][i]     = '0;
			end
		end

		dir_tab = '{
			// after reset: zero query, then zero newest entry
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 42'd0}},
			'{'{srth_pkg::OP_LOOKUP, 2'd1, 32'h0, 32'h0, 32'hffff_ffff}, 1'b1,
				'{1'b0, 42'd0}},
			// largest ntp time
			'{'{srth_pkg::OP_RECORD, 2'd0, 32'hffff_ffff, 32'hffff_ffff, 32'h0}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b1,
				'{1'b1, 42'd4294967296000}},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 42'd0}},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'h1234_5678}, 1'b1,
				'{1'b0, 42'd0}},
			// zero compact value as newest entry hides older matches
			'{'{srth_pkg::OP_RECORD, 2'd0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b1,
				'{1'b0, 42'd0}},
			// same compact value twice, newest wins
			'{'{srth_pkg::OP_RECORD, 2'd0, 32'h0001_0002, 32'h8000_0000, 32'h0}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'h0002_8000}, 1'b0, '0},
			'{'{srth_pkg::OP_RECORD, 2'd0, 32'h1234_0002, 32'h8000_ffff, 32'h0}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'h0002_8000}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b0, '0},
			// rounding of the fraction just below and above half a millisecond, then unused request fields set
			'{'{srth_pkg::OP_RECORD, 2'd3, 32'h0000_0005, 32'h0020_c49b, 32'h0}, 1'b0, '0},
			'{'{srth_pkg::OP_RECORD, 2'd3, 32'h0000_0006, 32'h0020_c49c, 32'h0}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd3, 32'h0, 32'h0, 32'h0005_0020}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd3, 32'h0, 32'h0, 32'h0006_0020}, 1'b0, '0},
			'{'{srth_pkg::OP_RECORD, 2'd2, 32'h0, 32'h0001_0000, 32'h0}, 1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd2, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001},
				1'b0, '0},
			'{'{srth_pkg::OP_RECORD, 2'd1, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff},
				1'b0, '0},
			'{'{srth_pkg::OP_LOOKUP, 2'd1, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_5555},
				1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < N_DIRECTED; n++)
			send_req(dir_tab[n].req, $urandom_range(0, 10), dir_tab[n].fixed,
				dir_tab[n].rsp);

		no_gaps = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 50 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			r.op           = $urandom_range(0, 1) ? srth_pkg::OP_LOOKUP : srth_pkg::OP_RECORD;
			r.stream_slot  = srth_pkg::SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
			r.ntp_seconds  = $urandom;
			r.ntp_fraction = $urandom;
			r.query_report = $urandom;
			slot           = 32'(r.stream_slot);
			pick           = $urandom_range(0, 99);
			if (r.op == srth_pkg::OP_RECORD) begin
				if (pick < 10) begin
					r.ntp_seconds[15:0]   = '0;
					r.ntp_fraction[31:16] = '0;
				end else if (pick < 30 && sent_log[slot].size() > 0) begin
					// reuse a compact value with a different send time
					c = sent_log[slot][$urandom_range(0, sent_log[slot].size() - 1)];
					r.ntp_seconds[15:0]   = c[31:16];
					r.ntp_fraction[31:16] = c[15:0];
				end
			end else begin
				if (pick < 8)
					r.query_report = '0;
				else if (pick < 80 && sent_log[slot].size() > 0)
					r.query_report =
						sent_log[slot][$urandom_range(0, sent_log[slot].size() - 1)];
			end
			gap = no_gaps ? 0 : $urandom_range(0, 10);
			send_req(r, gap, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sender_report_time_history.f
+incdir+rtl/core
rtl/core/srth_pkg.sv
rtl/core/srth_cell.sv
rtl/core/sender_report_time_history.sv
dv/tb.sv
